// ===== rtl/mhk_pkg.sv =====
// shared types, codes and helper functions of the hunt-and-kill maze generator
// used by maze_hunt_and_kill_generator and mhk_checker; no dependencies

package mhk_pkg;

	localparam int GRID_COLS_DEF = 32;
	localparam int GRID_ROWS_DEF = 32;

	// columns examined per cycle while hunting through one row
	localparam int CHUNK_W = 16;

	// wide enough for any coordinate or grid size in range
	localparam int COORD_W = 9;

	typedef enum logic [1:0] {
		EV_START = 2'd0,
		EV_WALK  = 2'd1,
		EV_HUNT  = 2'd2,
		EV_DONE  = 2'd3
	} ev_t;

	typedef enum logic [1:0] {
		DIR_LEFT  = 2'd0,
		DIR_UP    = 2'd1,
		DIR_RIGHT = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_CTR,
		ST_RD_UP,
		ST_RD_DN,
		ST_RD_LAST,
		ST_WALK,
		ST_HROW,
		ST_HSCAN,
		ST_HPICK,
		ST_OUT
	} state_t;

	// 4^k is 1 mod 3, so summing base-4 digits keeps the residue
	function automatic logic [1:0] mod3_16(input logic [15:0] v);
		logic [4:0] s;
		logic [2:0] t;
		logic [2:0] u;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		u = 3'(t[1:0]) + 3'(t[2]);
		if (u >= 3'd3) begin
			mod3_16 = 2'(u - 3'd3);
		end else begin
			mod3_16 = u[1:0];
		end
	endfunction

	// picks the qualifying direction at index rnd mod count, in order left, up, right, down
	function automatic dir_t pick_dir(input logic [3:0] mask, input logic [1:0] rnd_lo,
			input logic [1:0] rnd_m3);
		logic [2:0] n;
		logic [1:0] idx;
		logic [1:0] cnt;
		n = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);
		case (n)
			3'd2: idx = {1'b0, rnd_lo[0]};
			3'd3: idx = rnd_m3;
			3'd4: idx = rnd_lo;
			default: idx = '0;
		endcase
		pick_dir = DIR_LEFT;
		cnt = '0;
		for (int d = 0; d < 4; d++) begin
			if (mask[d]) begin
				if (cnt == idx) begin
					pick_dir = dir_t'(2'(d));
				end
				cnt = cnt + 1'b1;
			end
		end
	endfunction

	function automatic dir_t dir_back(input dir_t d);
		unique case (d)
			DIR_LEFT:  dir_back = DIR_RIGHT;
			DIR_UP:    dir_back = DIR_DOWN;
			DIR_RIGHT: dir_back = DIR_LEFT;
			default:   dir_back = DIR_UP;
		endcase
	endfunction

endpackage

// ===== rtl/maze_hunt_and_kill_generator.sv =====
// hunt-and-kill maze generator: sequencer, row-wide visited memory and result register
// depends on mhk_pkg
//
// usage:
// - input channel (in_valid/in_ready) takes one command per transfer: cmd 0 starts a new
//   maze at start_row/start_col (saturated to the grid), cmd 1 performs one step
// - output channel (out_valid/out_ready) gives exactly one result per command:
//   event_res, cell_row, cell_col, link_dir
// - visited cells live in a memory of GRID_ROWS words, one bit per column, read one row per
//   cycle through a registered port; a flip-flop per row marks rows written since the last
//   start, an unmarked row reads as all clear, so start and reset need no clearing pass
// - start, or a step with no active maze: no row read, idle goes straight to the output state
// - walk step: three row reads through the single read port, then decide, then result
// - hunt: after the failed walk, every row from row 0 up to the joined cell is read again
//   and scanned in groups of 16 columns, then the cell is joined and the result loaded; a
//   fruitless scan of the whole grid finishes the maze
// - one command is processed at a time; in_ready is high only while the sequencer is idle
// - a finished result waits in the output register while the next command is taken; if the
//   receiver still stalls when that command is done, the sequencer holds until it drains
// - reset: no maze active (steps report completion), output channel empty

module maze_hunt_and_kill_generator #(
	parameter int GRID_COLS = mhk_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = mhk_pkg::GRID_ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [4:0] start_row,
	input  logic [4:0] start_col,
	input  logic [15:0] rnd,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_res,
	output logic [4:0] cell_row,
	output logic [4:0] cell_col,
	output logic [1:0] link_dir
);

	localparam int RW   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int CW   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int CHK  = mhk_pkg::CHUNK_W;
	localparam int NCH  = (GRID_COLS + CHK - 1) / CHK;
	localparam int KW   = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PADW = NCH * CHK;
	localparam int XW   = mhk_pkg::COORD_W;
	localparam int IW   = $clog2(CHK);

	mhk_pkg::state_t state_q, state_d;

	// visited memory, one word per row
	logic [GRID_COLS-1:0] vis_mem [GRID_ROWS];
	logic [GRID_ROWS-1:0] row_vld_q;

	logic                 rd_en;
	logic [RW-1:0]        rd_addr;
	logic [GRID_COLS-1:0] rd_data_s1;
	logic                 rd_vld_s1;
	logic                 wr_en;
	logic [RW-1:0]        wr_addr;
	logic [GRID_COLS-1:0] wr_data;

	logic [GRID_COLS-1:0] row_ctr_q, row_up_q, row_dn_q;
	logic [RW-1:0]        fr_q;
	logic                 hunt_q;
	logic [RW-1:0]        cur_row_q;
	logic [CW-1:0]        cur_col_q;
	logic                 finished_q;
	logic [1:0]           rnd_lo_q, rnd_m3_q;
	logic [PADW-1:0]      cand_q;
	logic [KW-1:0]        chunk_q;
	logic [CW-1:0]        hcol_q;

	mhk_pkg::ev_t  res_ev_q;
	logic [4:0]    res_row_q, res_col_q;
	mhk_pkg::dir_t res_dir_q;

	logic          out_valid_q;
	mhk_pkg::ev_t  out_ev_q;
	logic [4:0]    out_row_q, out_col_q;
	mhk_pkg::dir_t out_dir_q;

	logic                 in_xfer, start_go, out_load;
	logic [RW-1:0]        st_row;
	logic [CW-1:0]        st_col;
	logic                 has_up, has_dn;
	logic [3:0]           open_w, seen_h;
	logic                 walk_any;
	mhk_pkg::dir_t        walk_dir, hunt_dir;
	logic [RW-1:0]        walk_row;
	logic [CW-1:0]        walk_col;
	logic [GRID_COLS-1:0] walk_base;
	logic [GRID_COLS-1:0] cand_row;
	logic [CHK-1:0]       chunk_lo;
	logic                 chunk_hit;
	logic [IW-1:0]        chunk_idx;
	logic [CW-1:0]        hunt_col;
	logic                 last_chunk, last_row, hunt_none;

	function automatic logic [GRID_COLS-1:0] col_bit(input logic [CW-1:0] c);
		col_bit = '0;
		col_bit[c] = 1'b1;
	endfunction

	function automatic logic [GRID_ROWS-1:0] row_bit(input logic [RW-1:0] r);
		row_bit = '0;
		row_bit[r] = 1'b1;
	endfunction

	function automatic logic [3:0] nbr_exist(input logic [CW-1:0] c, input logic up_ok,
			input logic dn_ok);
		nbr_exist[0] = (c != '0);
		nbr_exist[1] = up_ok;
		nbr_exist[2] = (XW'(c) < XW'(GRID_COLS - 1));
		nbr_exist[3] = dn_ok;
	endfunction

	// visited bits around column c; edge positions are masked by nbr_exist
	function automatic logic [3:0] nbr_seen(input logic [CW-1:0] c,
			input logic [GRID_COLS-1:0] ctr, input logic [GRID_COLS-1:0] up,
			input logic [GRID_COLS-1:0] dn);
		logic [GRID_COLS-1:0] from_left, from_right;
		from_left  = ctr << 1;
		from_right = ctr >> 1;
		nbr_seen[0] = from_left[c];
		nbr_seen[1] = up[c];
		nbr_seen[2] = from_right[c];
		nbr_seen[3] = dn[c];
	endfunction

	assign in_xfer  = in_valid && in_ready;
	assign start_go = in_xfer && !cmd;

	assign st_row = (XW'(start_row) >= XW'(GRID_ROWS)) ? RW'(GRID_ROWS - 1) : RW'(start_row);
	assign st_col = (XW'(start_col) >= XW'(GRID_COLS)) ? CW'(GRID_COLS - 1) : CW'(start_col);

	assign has_up = (XW'(fr_q) < XW'(GRID_ROWS - 1));
	assign has_dn = (fr_q != '0);

	// walk decision around the current cell
	assign open_w = nbr_exist(cur_col_q, has_up, has_dn)
		& ~nbr_seen(cur_col_q, row_ctr_q, row_up_q, row_dn_q);
	assign walk_any = |open_w;
	assign walk_dir = mhk_pkg::pick_dir(open_w, rnd_lo_q, rnd_m3_q);

	always_comb begin
		walk_row  = fr_q;
		walk_col  = cur_col_q;
		walk_base = row_ctr_q;
		case (walk_dir)
			mhk_pkg::DIR_LEFT: walk_col = cur_col_q - 1'b1;
			mhk_pkg::DIR_UP: begin
				walk_row  = fr_q + 1'b1;
				walk_base = row_up_q;
			end
			mhk_pkg::DIR_RIGHT: walk_col = cur_col_q + 1'b1;
			default: begin
				walk_row  = fr_q - 1'b1;
				walk_base = row_dn_q;
			end
		endcase
	end

	// unvisited cells of the row that touch a visited cell; missing rows read as zero
	assign cand_row = ~row_ctr_q & ((row_ctr_q << 1) | (row_ctr_q >> 1) | row_up_q | row_dn_q);

	assign chunk_lo  = cand_q[CHK-1:0];
	assign chunk_hit = |chunk_lo;

	always_comb begin
		chunk_idx = '0;
		for (int i = CHK - 1; i >= 0; i--) begin
			if (chunk_lo[i]) begin
				chunk_idx = IW'(i);
			end
		end
	end

	assign hunt_col   = CW'(XW'(chunk_q) * XW'(CHK) + XW'(chunk_idx));
	assign last_chunk = (chunk_q == KW'(NCH - 1));
	assign last_row   = (XW'(fr_q) == XW'(GRID_ROWS - 1));
	assign hunt_none  = (state_q == mhk_pkg::ST_HSCAN) && !chunk_hit && last_chunk && last_row;

	assign seen_h   = nbr_exist(hcol_q, has_up, has_dn)
		& nbr_seen(hcol_q, row_ctr_q, row_up_q, row_dn_q);
	assign hunt_dir = mhk_pkg::pick_dir(seen_h, rnd_lo_q, rnd_m3_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mhk_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = (!cmd || finished_q) ? mhk_pkg::ST_OUT : mhk_pkg::ST_RD_CTR;
				end
			end
			mhk_pkg::ST_RD_CTR:  state_d = mhk_pkg::ST_RD_UP;
			mhk_pkg::ST_RD_UP:   state_d = mhk_pkg::ST_RD_DN;
			mhk_pkg::ST_RD_DN:   state_d = mhk_pkg::ST_RD_LAST;
			mhk_pkg::ST_RD_LAST: state_d = hunt_q ? mhk_pkg::ST_HROW : mhk_pkg::ST_WALK;
			mhk_pkg::ST_WALK:    state_d = walk_any ? mhk_pkg::ST_OUT : mhk_pkg::ST_RD_CTR;
			mhk_pkg::ST_HROW:    state_d = mhk_pkg::ST_HSCAN;
			mhk_pkg::ST_HSCAN: begin
				if (chunk_hit) begin
					state_d = mhk_pkg::ST_HPICK;
				end else if (last_chunk) begin
					state_d = last_row ? mhk_pkg::ST_OUT : mhk_pkg::ST_RD_CTR;
				end
			end
			mhk_pkg::ST_HPICK: state_d = mhk_pkg::ST_OUT;
			mhk_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = mhk_pkg::ST_IDLE;
				end
			end
			default: state_d = mhk_pkg::ST_IDLE;
		endcase
	end

	// memory strobes and handshake outputs
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = fr_q;
		wr_en    = 1'b0;
		wr_addr  = fr_q;
		wr_data  = row_ctr_q | col_bit(hcol_q);
		unique case (state_q)
			mhk_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (start_go) begin
					wr_en   = 1'b1;
					wr_addr = st_row;
					wr_data = col_bit(st_col);
				end
			end
			mhk_pkg::ST_RD_CTR: rd_en = 1'b1;
			mhk_pkg::ST_RD_UP: begin
				rd_en   = has_up;
				rd_addr = fr_q + 1'b1;
			end
			mhk_pkg::ST_RD_DN: begin
				rd_en   = has_dn;
				rd_addr = fr_q - 1'b1;
			end
			mhk_pkg::ST_WALK: begin
				wr_en   = walk_any;
				wr_addr = walk_row;
				wr_data = walk_base | col_bit(walk_col);
			end
			mhk_pkg::ST_HPICK: wr_en = 1'b1;
			mhk_pkg::ST_OUT:   out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vis_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= vis_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mhk_pkg::ST_IDLE;
			row_vld_q   <= '0;
			rd_vld_s1   <= 1'b0;
			hunt_q      <= 1'b0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			finished_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en && row_vld_q[rd_addr];
			if (start_go) begin
				row_vld_q <= row_bit(st_row);
			end else if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (in_xfer) begin
				hunt_q <= 1'b0;
			end else if (state_q == mhk_pkg::ST_WALK && !walk_any) begin
				hunt_q <= 1'b1;
			end
			if (start_go) begin
				cur_row_q  <= st_row;
				cur_col_q  <= st_col;
				finished_q <= 1'b0;
			end else if (state_q == mhk_pkg::ST_WALK && walk_any) begin
				cur_row_q <= walk_row;
				cur_col_q <= walk_col;
			end else if (state_q == mhk_pkg::ST_HPICK) begin
				cur_row_q <= fr_q;
				cur_col_q <= hcol_q;
			end else if (hunt_none) begin
				finished_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			fr_q     <= cur_row_q;
			rnd_lo_q <= rnd[1:0];
			rnd_m3_q <= mhk_pkg::mod3_16(rnd);
			if (!cmd) begin
				res_ev_q  <= mhk_pkg::EV_START;
				res_row_q <= 5'(st_row);
				res_col_q <= 5'(st_col);
				res_dir_q <= mhk_pkg::DIR_LEFT;
			end else begin
				res_ev_q  <= mhk_pkg::EV_DONE;
				res_row_q <= '0;
				res_col_q <= '0;
				res_dir_q <= mhk_pkg::DIR_LEFT;
			end
		end
		unique case (state_q)
			mhk_pkg::ST_RD_UP:   row_ctr_q <= rd_vld_s1 ? rd_data_s1 : '0;
			mhk_pkg::ST_RD_DN:   row_up_q  <= rd_vld_s1 ? rd_data_s1 : '0;
			mhk_pkg::ST_RD_LAST: row_dn_q  <= rd_vld_s1 ? rd_data_s1 : '0;
			mhk_pkg::ST_WALK: begin
				if (walk_any) begin
					res_ev_q  <= mhk_pkg::EV_WALK;
					res_row_q <= 5'(walk_row);
					res_col_q <= 5'(walk_col);
					res_dir_q <= mhk_pkg::dir_back(walk_dir);
				end else begin
					fr_q <= '0;
				end
			end
			mhk_pkg::ST_HROW: begin
				cand_q  <= PADW'(cand_row);
				chunk_q <= '0;
			end
			mhk_pkg::ST_HSCAN: begin
				if (chunk_hit) begin
					hcol_q <= hunt_col;
				end else if (!last_chunk) begin
					cand_q  <= cand_q >> CHK;
					chunk_q <= chunk_q + 1'b1;
				end else if (!last_row) begin
					fr_q <= fr_q + 1'b1;
				end
			end
			mhk_pkg::ST_HPICK: begin
				res_ev_q  <= mhk_pkg::EV_HUNT;
				res_row_q <= 5'(fr_q);
				res_col_q <= 5'(hcol_q);
				res_dir_q <= hunt_dir;
			end
			default: ;
		endcase
		if (out_load) begin
			out_ev_q  <= res_ev_q;
			out_row_q <= res_row_q;
			out_col_q <= res_col_q;
			out_dir_q <= res_dir_q;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = out_ev_q;
	assign cell_row  = out_row_q;
	assign cell_col  = out_col_q;
	assign link_dir  = out_dir_q;

endmodule

// ===== rtl/mhk_checker.sv =====
// port-level checks for maze_hunt_and_kill_generator, attached by the bind at the end
// depends on mhk_pkg

module mhk_checker #(
	parameter int GRID_COLS = mhk_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = mhk_pkg::GRID_ROWS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       cmd,
	input logic [4:0] start_row,
	input logic [4:0] start_col,
	input logic [15:0] rnd,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] event_res,
	input logic [4:0] cell_row,
	input logic [4:0] cell_col,
	input logic [1:0] link_dir
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(cmd) && $stable(start_row)
			&& $stable(start_col) && $stable(rnd))
		else $error("command changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(cell_row)
			&& $stable(cell_col) && $stable(link_dir))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command taken while previous one in progress");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == mhk_pkg::EV_DONE |->
			cell_row == '0 && cell_col == '0 && link_dir == mhk_pkg::DIR_LEFT)
		else $error("completion result carries a cell");

	// start result lies on the grid and opens no link
	a_start_cell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == mhk_pkg::EV_START |->
			int'(cell_row) < GRID_ROWS && int'(cell_col) < GRID_COLS
			&& link_dir == mhk_pkg::DIR_LEFT)
		else $error("start result off the grid or with a link");

endmodule

bind maze_hunt_and_kill_generator mhk_checker #(
	.GRID_COLS(GRID_COLS),
	.GRID_ROWS(GRID_ROWS)
) u_mhk_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for maze_hunt_and_kill_generator: directed and random command streams with
// random sender gaps and receiver stalls, every result checked against a local maze model
// depends on mhk_pkg and the generator rtl

module tb_top;

	localparam int ROWS = mhk_pkg::GRID_ROWS_DEF;
	localparam int COLS = mhk_pkg::GRID_COLS_DEF;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_CYCLES = 300;
	localparam int LONG_HOLD = 400;
	// a full maze alone needs about a thousand steps
	localparam int ITEM_BUDGET = 1100;
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	typedef struct packed {
		mhk_pkg::ev_t ev;
		logic [4:0] row;
		logic [4:0] col;
		mhk_pkg::dir_t dir;
	} maze_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_START;
	logic [4:0] start_row = '0;
	logic [4:0] start_col = '0;
	logic [15:0] rnd = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] event_res;
	logic [4:0] cell_row;
	logic [4:0] cell_col;
	logic [1:0] link_dir;

	// local copy of the generator state
	bit visited [ROWS][COLS];
	int cur_r = 0;
	int cur_c = 0;
	bit maze_done = 1'b1;

	maze_event_t events_due[$];
	int errors = 0;
	int cycles = 0;
	int items_sent = 0;

	// sender idling
	int burst_left = 0;
	bit steady = 1'b0;

	// receiver stall control
	bit hold_req = 1'b0;
	int hold_cnt = 0;
	int rx_mode = 0;
	logic [7:0] rx_pattern = 8'hff;

	maze_hunt_and_kill_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.start_row(start_row),
		.start_col(start_col),
		.rnd(rnd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_res(event_res),
		.cell_row(cell_row),
		.cell_col(cell_col),
		.link_dir(link_dir)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	function automatic maze_event_t mk_event(mhk_pkg::ev_t e, int r, int c, int d);
		maze_event_t m;
		m.ev = e;
		m.row = 5'(r);
		m.col = 5'(c);
		m.dir = mhk_pkg::dir_t'(2'(d));
		return m;
	endfunction

	function automatic bit step_to(int r, int c, int d, output int nr, output int nc);
		nr = r;
		nc = c;
		case (d)
			mhk_pkg::DIR_LEFT: begin
				if (c == 0) return 1'b0;
				nc = c - 1;
			end
			mhk_pkg::DIR_UP: begin
				if (r + 1 >= ROWS) return 1'b0;
				nr = r + 1;
			end
			mhk_pkg::DIR_RIGHT: begin
				if (c + 1 >= COLS) return 1'b0;
				nc = c + 1;
			end
			default: begin
				if (r == 0) return 1'b0;
				nr = r - 1;
			end
		endcase
		return 1'b1;
	endfunction

	// bit d set when neighbour d exists and its visited flag equals want
	function automatic logic [3:0] dir_mask(int r, int c, bit want);
		logic [3:0] m;
		int nr, nc;
		m = '0;
		for (int d = 0; d < 4; d++) begin
			if (step_to(r, c, d, nr, nc) && visited[nr][nc] == want) m[d] = 1'b1;
		end
		return m;
	endfunction

	function automatic int choose_dir(logic [3:0] m, int unsigned v);
		int k;
		k = v % $countones(m);
		for (int d = 0; d < 4; d++) begin
			if (m[d]) begin
				if (k == 0) return d;
				k--;
			end
		end
		return 0;
	endfunction

	function automatic maze_event_t predict_maze_step(logic c_in, int sr, int sc, int unsigned v);
		logic [3:0] m;
		int d, nr, nc;
		if (c_in == CMD_START) begin
			if (sr >= ROWS) sr = ROWS - 1;
			if (sc >= COLS) sc = COLS - 1;
			foreach (visited[i, j]) visited[i][j] = 1'b0;
			visited[sr][sc] = 1'b1;
			cur_r = sr;
			cur_c = sc;
			maze_done = 1'b0;
			return mk_event(mhk_pkg::EV_START, sr, sc, mhk_pkg::DIR_LEFT);
		end
		if (maze_done) return mk_event(mhk_pkg::EV_DONE, 0, 0, mhk_pkg::DIR_LEFT);
		m = dir_mask(cur_r, cur_c, 1'b0);
		if (m != '0) begin
			d = choose_dir(m, v);
			void'(step_to(cur_r, cur_c, d, nr, nc));
			visited[nr][nc] = 1'b1;
			cur_r = nr;
			cur_c = nc;
			// link points back to where the walk came from
			return mk_event(mhk_pkg::EV_WALK, nr, nc, d ^ 2);
		end
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				if (!visited[r][c]) begin
					m = dir_mask(r, c, 1'b1);
					if (m != '0) begin
						d = choose_dir(m, v);
						visited[r][c] = 1'b1;
						cur_r = r;
						cur_c = c;
						return mk_event(mhk_pkg::EV_HUNT, r, c, d);
					end
				end
			end
		end
		maze_done = 1'b1;
		return mk_event(mhk_pkg::EV_DONE, 0, 0, mhk_pkg::DIR_LEFT);
	endfunction

	task automatic send_cmd(logic c_in, logic [4:0] r, logic [4:0] c, logic [15:0] v);
		int gap;
		in_valid <= 1'b1;
		cmd <= c_in;
		start_row <= r;
		start_col <= c;
		rnd <= v;
		do @(posedge clk); while (!in_ready);
		events_due = {events_due, predict_maze_step(c_in, r, c, v)};
		items_sent++;
		if (steady) return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 10);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
				$urandom_range(0, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_rnd();
		case ($urandom_range(0, 15))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_output
		maze_event_t want;
		if (arst_n && out_valid && out_ready) begin
			if (events_due.size() == 0) begin
				$display("%0t: result with none expected, actual event %0d row %0d col %0d dir %0d",
					$time, event_res, cell_row, cell_col, link_dir);
				errors++;
			end else begin
				want = events_due.pop_front();
				compare_field("event_res", want.ev, event_res);
				compare_field("cell_row", want.row, cell_row);
				compare_field("cell_col", want.col, cell_col);
				compare_field("link_dir", want.dir, link_dir);
			end
		end
	end

	// receiver: random stall mode and pattern, redrawn periodically, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			if (cycles % 64 == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_pattern = 8'($urandom_range(0, 255));
			end
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= rx_pattern[cycles % 8];
			endcase
		end
	end

	task automatic test_step_without_maze();
		send_cmd(CMD_STEP, 5'd0, 5'd0, 16'h0000);
		send_cmd(CMD_STEP, 5'd31, 5'd31, 16'hffff);
	endtask

	// corners and a middle cell, walking with the extremes of rnd
	task automatic test_corner_starts();
		logic [4:0] rows [5] = '{5'd0, 5'd31, 5'd0, 5'd31, 5'd15};
		logic [4:0] cols [5] = '{5'd0, 5'd31, 5'd31, 5'd0, 5'd16};
		for (int i = 0; i < 5; i++) begin
			send_cmd(CMD_START, rows[i], cols[i], 16'hffff);
			send_cmd(CMD_STEP, 5'd0, 5'd0, 16'h0000);
			send_cmd(CMD_STEP, 5'd31, 5'd31, 16'hffff);
		end
		send_cmd(CMD_START, 5'd10, 5'd10, 16'h0000);
		send_cmd(CMD_STEP, 5'd0, 5'd0, 16'h0001);
		send_cmd(CMD_STEP, 5'd0, 5'd0, 16'h0002);
		send_cmd(CMD_STEP, 5'd0, 5'd0, 16'h8003);
	endtask

	// receiver holds off while the sender keeps going, so the input side stalls
	task automatic test_output_backpressure();
		send_cmd(CMD_START, 5'd5, 5'd5, 16'h0000);
		hold_req = 1'b1;
		steady = 1'b1;
		for (int i = 0; i < 12; i++) send_cmd(CMD_STEP, 5'd0, 5'd0, pick_rnd());
		steady = 1'b0;
	endtask

	// one maze to the end, then steps on the finished maze
	task automatic test_full_maze();
		send_cmd(CMD_START, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), pick_rnd());
		while (!maze_done) send_cmd(CMD_STEP, 5'($urandom_range(0, 31)),
			5'($urandom_range(0, 31)), pick_rnd());
		for (int i = 0; i < 3; i++) send_cmd(CMD_STEP, 5'd0, 5'd0, pick_rnd());
	endtask

	task automatic test_random_mazes();
		int steps;
		while (items_sent < ITEM_BUDGET) begin
			send_cmd(CMD_START, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
				pick_rnd());
			steps = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 400) :
				$urandom_range(0, 80);
			for (int i = 0; i < steps && items_sent < ITEM_BUDGET; i++) begin
				send_cmd(CMD_STEP, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
					pick_rnd());
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_step_without_maze();
		test_corner_starts();
		test_output_backpressure();
		test_full_maze();
		test_random_mazes();
		in_valid <= 1'b0;
		while (events_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mhk_pkg.sv
rtl/maze_hunt_and_kill_generator.sv
rtl/mhk_checker.sv
dv/tb_top.sv
